@@ hdl/typed_posting_list_update_core_assert.svh @@
// Assertion macros shared by the posting line update core.
// Needs nothing else; files that assert include this by bare name.
`ifndef TYPED_POSTING_LIST_UPDATE_CORE_ASSERT_SVH
`define TYPED_POSTING_LIST_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TPLU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("posting line core: assertion failed");

// Next-cycle implication, disabled during reset
`define TPLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("posting line core: assertion failed");

`endif

@@ hdl/tplu_pkg.sv @@
// Shared constants, types and helpers of the posting line update core.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none

package tplu_pkg;

  localparam int MAX_TYPES = 8;
  localparam int MAX_IDS   = 256;

  localparam int SLOT_W    = $clog2((MAX_TYPES > 1) ? MAX_TYPES : 2);
  localparam int USED_W    = $clog2(MAX_TYPES + 1);
  localparam int IDX_W     = $clog2(MAX_IDS);
  localparam int CNT_W     = $clog2(MAX_IDS + 1);
  localparam int ADDR_W    = SLOT_W + IDX_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int BYTES_W   = $clog2(5 * MAX_IDS + 1);
  localparam int TOT_W     = $clog2(MAX_TYPES * (5 * MAX_IDS + 7) + 2);

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [USED_W-1:0]  used_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [BYTES_W-1:0] bytes_t;
  typedef logic [TOT_W-1:0]   tot_t;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_RD_ID  = 3'd2,
    CMD_SEC_BY = 3'd3,
    CMD_TOT_BY = 3'd4,
    CMD_RD_TYP = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_ZERO      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_INDEX     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SLOT,
    S_RDWAIT,
    S_FIND,
    S_UP,
    S_DOWN,
    S_SUM,
    S_TOTAL,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MODE_FIND,
    MODE_UP,
    MODE_DOWN,
    MODE_SUM
  } mode_t;

  typedef enum logic [1:0] {
    VAL_ID,
    VAL_BYTES,
    VAL_TOTAL,
    VAL_TYPE
  } vsel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    slot_adv;
    logic    tot_add;
    logic    open;
    logic    close;
    logic    strm_init;
    mode_t   mode;
    logic    strm_run;
    logic    wr_id;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    bytes_ld;
    logic    rd_pos;
    logic    st_ld;
    status_t st_code;
    logic    val_ld;
    vsel_t   val_sel;
    logic    out_ld;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic zero_arg;
    logic slot_more;
    logic slot_hit;
    logic tbl_full;
    logic pos_in_sec;
    logic pos_in_tbl;
    logic sec_full;
    logic strm_done;
    logic find_hit;
    logic cnt_one;
    logic tot_more;
  } dp_stat_t;

  // Bytes taken by a 7-bit varint of v
  function automatic logic [2:0] varint_len(input logic [31:0] v);
    logic [2:0] n;
    if (v < 32'h0000_0080)      n = 3'd1;
    else if (v < 32'h0000_4000) n = 3'd2;
    else if (v < 32'h0020_0000) n = 3'd3;
    else if (v < 32'h1000_0000) n = 3'd4;
    else                        n = 3'd5;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/typed_posting_list_update_core.sv @@
// Read type answers from the decode state; section bytes, total bytes and read id first walk
// the sections; add or delete also make a search-and-shift pass and a resize pass over the row.
// Throughput: one item at a time; the next beat is taken once the result sits in the
// output register. Reset (rst, synchronous) empties the line at once; no clearing pass.
`default_nettype none
`include "typed_posting_list_update_core_assert.svh"

module typed_posting_list_update_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,  // type_code[31:0], doc_number[63:32], position[71:64]
  input  wire logic [2:0]  s_tuser,  // cmd[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // value[31:0]
  output logic [2:0]       m_tuser   // status[2:0]
);

  tplu_pkg::dp_cmd_t  cmd;
  tplu_pkg::dp_stat_t stat;
  logic [2:0]         res_status;
  logic [31:0]        res_value;
  logic               out_free;

  assign out_free = !m_tvalid || m_tready;

  tplu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  tplu_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_cmd        (s_tuser),
    .in_type_code  (s_tdata[31:0]),
    .in_doc_number (s_tdata[63:32]),
    .in_position   (s_tdata[71:64]),
    .cmd           (cmd),
    .stat          (stat),
    .res_status    (res_status),
    .res_value     (res_value)
  );

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      m_tdata <= res_value;
      m_tuser <= res_status;
    end
  end

  // A result is loaded only into a free output register, and then shown
  `TPLU_ASSERT_NOW(a_load_free, clk, rst, cmd.out_ld, out_free)
  `TPLU_ASSERT_NEXT(a_load_shows, clk, rst, cmd.out_ld, m_tvalid)

endmodule

`default_nettype wire

@@ hdl/tplu_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
`default_nettype none

module tplu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/tplu_ctrl.sv @@
// Controller state machine of the posting line update core.
// Depends on tplu_pkg; drives the datapath through dp_cmd_t.
`default_nettype none
`include "typed_posting_list_update_core_assert.svh"

module tplu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               out_free,
  input  wire tplu_pkg::dp_stat_t stat,
  output tplu_pkg::dp_cmd_t       cmd
);

  tplu_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tplu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      tplu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = tplu_pkg::S_DECODE;
        end
      end
      tplu_pkg::S_DECODE: begin
        unique case (stat.cmd)
          tplu_pkg::CMD_ADD, tplu_pkg::CMD_DELETE: begin
            if (stat.zero_arg) begin
              cmd.st_ld   = 1'b1;
              cmd.st_code = tplu_pkg::STAT_ZERO;
              state_next  = tplu_pkg::S_FINISH;
            end else begin
              state_next = tplu_pkg::S_SLOT;
            end
          end
          tplu_pkg::CMD_RD_ID, tplu_pkg::CMD_SEC_BY: state_next = tplu_pkg::S_SLOT;
          tplu_pkg::CMD_TOT_BY: state_next = tplu_pkg::S_TOTAL;
          tplu_pkg::CMD_RD_TYP: begin
            if (stat.pos_in_tbl) begin
              cmd.val_ld  = 1'b1;
              cmd.val_sel = tplu_pkg::VAL_TYPE;
            end else begin
              cmd.st_ld   = 1'b1;
              cmd.st_code = tplu_pkg::STAT_INDEX;
            end
            state_next = tplu_pkg::S_FINISH;
          end
          default: state_next = tplu_pkg::S_FINISH;
        endcase
      end
      tplu_pkg::S_SLOT: begin
        // Walk the ordered sections until the type is reached
        if (stat.slot_more) begin
          cmd.slot_adv = 1'b1;
        end else begin
          state_next = tplu_pkg::S_FINISH;
          unique case (stat.cmd)
            tplu_pkg::CMD_ADD: begin
              if (stat.slot_hit || !stat.tbl_full) begin
                cmd.open      = !stat.slot_hit;
                cmd.strm_init = 1'b1;
                cmd.mode      = tplu_pkg::MODE_FIND;
                state_next    = tplu_pkg::S_FIND;
              end else begin
                cmd.st_ld   = 1'b1;
                cmd.st_code = tplu_pkg::STAT_FULL;
              end
            end
            tplu_pkg::CMD_DELETE: begin
              if (stat.slot_hit) begin
                cmd.strm_init = 1'b1;
                cmd.mode      = tplu_pkg::MODE_FIND;
                state_next    = tplu_pkg::S_FIND;
              end else begin
                cmd.st_ld   = 1'b1;
                cmd.st_code = tplu_pkg::STAT_NOT_FOUND;
              end
            end
            tplu_pkg::CMD_RD_ID: begin
              if (!stat.slot_hit) begin
                cmd.st_ld   = 1'b1;
                cmd.st_code = tplu_pkg::STAT_NOT_FOUND;
              end else if (!stat.pos_in_sec) begin
                cmd.st_ld   = 1'b1;
                cmd.st_code = tplu_pkg::STAT_INDEX;
              end else begin
                cmd.rd_pos = 1'b1;
                state_next = tplu_pkg::S_RDWAIT;
              end
            end
            tplu_pkg::CMD_SEC_BY: begin
              if (stat.slot_hit) begin
                cmd.val_ld  = 1'b1;
                cmd.val_sel = tplu_pkg::VAL_BYTES;
              end else begin
                cmd.st_ld   = 1'b1;
                cmd.st_code = tplu_pkg::STAT_NOT_FOUND;
              end
            end
            default: state_next = tplu_pkg::S_FINISH;
          endcase
        end
      end
      tplu_pkg::S_RDWAIT: begin
        cmd.val_ld  = 1'b1;
        cmd.val_sel = tplu_pkg::VAL_ID;
        state_next  = tplu_pkg::S_FINISH;
      end
      tplu_pkg::S_FIND: begin
        cmd.strm_run = 1'b1;
        if (stat.strm_done) begin
          state_next = tplu_pkg::S_FINISH;
          if (stat.cmd == tplu_pkg::CMD_ADD) begin
            // A duplicate id is accepted and changes nothing
            if (!stat.find_hit) begin
              if (stat.sec_full) begin
                cmd.st_ld   = 1'b1;
                cmd.st_code = tplu_pkg::STAT_FULL;
              end else begin
                cmd.strm_init = 1'b1;
                cmd.mode      = tplu_pkg::MODE_UP;
                state_next    = tplu_pkg::S_UP;
              end
            end
          end else begin
            if (stat.find_hit) begin
              cmd.strm_init = 1'b1;
              cmd.mode      = tplu_pkg::MODE_DOWN;
              state_next    = tplu_pkg::S_DOWN;
            end else begin
              cmd.st_ld   = 1'b1;
              cmd.st_code = tplu_pkg::STAT_NOT_FOUND;
            end
          end
        end
      end
      tplu_pkg::S_UP: begin
        cmd.strm_run = 1'b1;
        if (stat.strm_done) begin
          cmd.wr_id     = 1'b1;
          cmd.cnt_inc   = 1'b1;
          cmd.strm_init = 1'b1;
          cmd.mode      = tplu_pkg::MODE_SUM;
          state_next    = tplu_pkg::S_SUM;
        end
      end
      tplu_pkg::S_DOWN: begin
        cmd.strm_run = 1'b1;
        if (stat.strm_done) begin
          // Drop the section when its last id goes
          if (stat.cnt_one) begin
            cmd.close  = 1'b1;
            state_next = tplu_pkg::S_FINISH;
          end else begin
            cmd.cnt_dec   = 1'b1;
            cmd.strm_init = 1'b1;
            cmd.mode      = tplu_pkg::MODE_SUM;
            state_next    = tplu_pkg::S_SUM;
          end
        end
      end
      tplu_pkg::S_SUM: begin
        cmd.strm_run = 1'b1;
        if (stat.strm_done) begin
          cmd.bytes_ld = 1'b1;
          state_next   = tplu_pkg::S_FINISH;
        end
      end
      tplu_pkg::S_TOTAL: begin
        if (stat.tot_more) begin
          cmd.slot_adv = 1'b1;
          cmd.tot_add  = 1'b1;
        end else begin
          cmd.val_ld  = 1'b1;
          cmd.val_sel = tplu_pkg::VAL_TOTAL;
          state_next  = tplu_pkg::S_FINISH;
        end
      end
      tplu_pkg::S_FINISH: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_next = tplu_pkg::S_IDLE;
        end
      end
      default: state_next = tplu_pkg::S_IDLE;
    endcase
  end

  // An accepted beat is decoded in the next cycle
  `TPLU_ASSERT_NEXT(a_accept_decode, clk, rst, state == tplu_pkg::S_IDLE && in_valid, state == tplu_pkg::S_DECODE)
  // A section is opened only from the slot walk of an add
  `TPLU_ASSERT_NOW(a_open_add, clk, rst, cmd.open, state == tplu_pkg::S_SLOT && stat.cmd == tplu_pkg::CMD_ADD)

endmodule

`default_nettype wire

@@ hdl/tplu_dp.sv @@
// Datapath of the posting line update core: section tables, row map,
// id store RAM and the streaming scan engine. Depends on tplu_pkg, tplu_ram.
`default_nettype none
`include "typed_posting_list_update_core_assert.svh"

module tplu_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [2:0]        in_cmd,
  input  wire logic [31:0]       in_type_code,
  input  wire logic [31:0]       in_doc_number,
  input  wire logic [7:0]        in_position,
  input  wire tplu_pkg::dp_cmd_t cmd,
  output tplu_pkg::dp_stat_t     stat,
  output logic [2:0]             res_status,
  output logic [31:0]            res_value
);

  // Section tables, kept in type order; map gives each slot's RAM row
  logic [31:0]     types  [tplu_pkg::MAX_TYPES];
  tplu_pkg::cnt_t   counts [tplu_pkg::MAX_TYPES];
  tplu_pkg::bytes_t bytes  [tplu_pkg::MAX_TYPES];
  tplu_pkg::slot_t  row_map[tplu_pkg::MAX_TYPES];
  tplu_pkg::used_t  used;
  tplu_pkg::used_t  i;

  // Latched item
  tplu_pkg::cmd_t cur_cmd;
  logic [31:0]    t;
  logic [31:0]    id;
  logic [7:0]     pos;

  // Scan engine
  tplu_pkg::mode_t  mode;
  tplu_pkg::cnt_t   rp;
  tplu_pkg::cnt_t   dk;
  tplu_pkg::cnt_t   k;
  logic             dv;
  logic [31:0]      prev;
  tplu_pkg::bytes_t sum;
  tplu_pkg::tot_t   acc;

  // RAM ports
  logic            ram_we;
  tplu_pkg::addr_t ram_waddr;
  logic [31:0]     ram_wdata;
  tplu_pkg::addr_t ram_raddr;
  logic [31:0]     ram_rdata;

  tplu_pkg::slot_t islot;
  tplu_pkg::slot_t phys;
  tplu_pkg::cnt_t  cur_cnt;
  tplu_pkg::cnt_t  rd_idx;
  tplu_pkg::cnt_t  k_now;
  logic            issue_ok;
  logic            in_tbl;

  assign islot   = tplu_pkg::slot_t'(i);
  assign phys    = row_map[islot];
  assign cur_cnt = counts[islot];
  assign in_tbl  = i < used;
  assign k_now   = dv ? dk : cur_cnt;

  // Read issue of the scan engine
  always_comb begin
    if (mode == tplu_pkg::MODE_UP) begin
      issue_ok = rp > k;
      rd_idx   = rp - 1'b1;
    end else begin
      issue_ok = rp < cur_cnt;
      rd_idx   = rp;
    end
  end

  // RAM address and write selection
  always_comb begin
    ram_raddr = cmd.rd_pos ? {phys, tplu_pkg::idx_t'(pos)} : {phys, rd_idx[tplu_pkg::IDX_W-1:0]};
    ram_we    = 1'b0;
    ram_waddr = {phys, k[tplu_pkg::IDX_W-1:0]};
    ram_wdata = id;
    if (cmd.wr_id) begin
      ram_we = 1'b1;
    end else if (cmd.strm_run && dv && mode == tplu_pkg::MODE_UP) begin
      ram_we    = 1'b1;
      ram_waddr = {phys, tplu_pkg::idx_t'(dk + 1'b1)};
      ram_wdata = ram_rdata;
    end else if (cmd.strm_run && dv && mode == tplu_pkg::MODE_DOWN) begin
      ram_we    = 1'b1;
      ram_waddr = {phys, tplu_pkg::idx_t'(dk - 1'b1)};
      ram_wdata = ram_rdata;
    end
  end

  tplu_ram #(
    .WIDTH (32),
    .DEPTH (tplu_pkg::RAM_DEPTH)
  ) u_id_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status towards the controller
  always_comb begin
    stat            = '0;
    stat.cmd        = cur_cmd;
    stat.zero_arg   = (t == 32'd0) || (id == 32'd0);
    stat.slot_more  = in_tbl && (types[islot] < t);
    stat.slot_hit   = in_tbl && (types[islot] == t);
    stat.tbl_full   = 32'(used) >= tplu_pkg::MAX_TYPES;
    stat.pos_in_sec = 32'(pos) < 32'(cur_cnt);
    stat.pos_in_tbl = 32'(pos) < 32'(used);
    stat.sec_full   = 32'(cur_cnt) >= tplu_pkg::MAX_IDS;
    stat.find_hit   = dv && (ram_rdata == id);
    stat.cnt_one    = cur_cnt == tplu_pkg::cnt_t'(1);
    stat.tot_more   = in_tbl;
    unique case (mode)
      tplu_pkg::MODE_FIND: stat.strm_done = (dv && ram_rdata >= id) || (!dv && rp >= cur_cnt);
      tplu_pkg::MODE_UP:   stat.strm_done = !dv && rp <= k;
      default:             stat.strm_done = !dv && rp >= cur_cnt;
    endcase
  end

  // Control state: tables with reset, slot counter, scan valid
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      i    <= '0;
      dv   <= 1'b0;
      for (int j = 0; j < tplu_pkg::MAX_TYPES; j++) begin
        counts[j]  <= '0;
        bytes[j]   <= '0;
        row_map[j] <= tplu_pkg::slot_t'(j);
      end
    end else begin
      if (cmd.latch) begin
        i <= '0;
      end else if (cmd.slot_adv) begin
        i <= i + 1'b1;
      end
      if (cmd.strm_init) begin
        dv <= 1'b0;
      end else if (cmd.strm_run) begin
        dv <= issue_ok;
      end
      // Open a slot: shift the later slots up, reuse the spare row
      if (cmd.open) begin
        for (int j = 1; j < tplu_pkg::MAX_TYPES; j++) begin
          if (j > int'(i) && j <= int'(used)) begin
            counts[j]  <= counts[j-1];
            bytes[j]   <= bytes[j-1];
            row_map[j] <= row_map[j-1];
          end
        end
        counts[islot]  <= '0;
        bytes[islot]   <= '0;
        row_map[islot] <= row_map[tplu_pkg::slot_t'(used)];
        used           <= used + 1'b1;
      end
      // Close a slot: shift the later slots down, park its row at the end
      if (cmd.close) begin
        for (int j = 0; j < tplu_pkg::MAX_TYPES - 1; j++) begin
          if (j >= int'(i) && j < int'(used) - 1) begin
            counts[j]  <= counts[j+1];
            bytes[j]   <= bytes[j+1];
            row_map[j] <= row_map[j+1];
          end
        end
        counts[tplu_pkg::slot_t'(used - 1'b1)]  <= '0;
        bytes[tplu_pkg::slot_t'(used - 1'b1)]   <= '0;
        row_map[tplu_pkg::slot_t'(used - 1'b1)] <= row_map[islot];
        used                                    <= used - 1'b1;
      end
      if (cmd.cnt_inc) begin
        counts[islot] <= cur_cnt + 1'b1;
      end
      if (cmd.cnt_dec) begin
        counts[islot] <= cur_cnt - 1'b1;
      end
      if (cmd.bytes_ld) begin
        bytes[islot] <= sum;
      end
    end
  end

  // Payload: types, latched item, scan registers, result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_cmd    <= tplu_pkg::cmd_t'(in_cmd);
      t          <= in_type_code;
      id         <= in_doc_number;
      pos        <= in_position;
      res_status <= tplu_pkg::STAT_OK;
      res_value  <= '0;
      acc        <= tplu_pkg::tot_t'(1);
    end
    if (cmd.open) begin
      for (int j = 1; j < tplu_pkg::MAX_TYPES; j++) begin
        if (j > int'(i) && j <= int'(used)) begin
          types[j] <= types[j-1];
        end
      end
      types[islot] <= t;
    end
    if (cmd.close) begin
      for (int j = 0; j < tplu_pkg::MAX_TYPES - 1; j++) begin
        if (j >= int'(i) && j < int'(used) - 1) begin
          types[j] <= types[j+1];
        end
      end
    end
    if (cmd.tot_add) begin
      acc <= acc + tplu_pkg::tot_t'(tplu_pkg::varint_len(types[islot]))
                 + tplu_pkg::tot_t'(tplu_pkg::varint_len(32'(bytes[islot])))
                 + tplu_pkg::tot_t'(bytes[islot]);
    end
    // Track the read pipe and catch the search result
    if (cmd.strm_run) begin
      dk <= rd_idx;
      if (mode == tplu_pkg::MODE_FIND && stat.strm_done) begin
        k <= k_now;
      end
    end
    // Start a scan, else advance it
    if (cmd.strm_init) begin
      mode <= cmd.mode;
      sum  <= '0;
      prev <= '0;
      unique case (cmd.mode)
        tplu_pkg::MODE_UP:   rp <= cur_cnt;
        tplu_pkg::MODE_DOWN: rp <= k_now + 1'b1;
        default:             rp <= '0;
      endcase
    end else if (cmd.strm_run) begin
      if (issue_ok) begin
        rp <= (mode == tplu_pkg::MODE_UP) ? rp - 1'b1 : rp + 1'b1;
      end
      if (dv && mode == tplu_pkg::MODE_SUM) begin
        sum  <= sum + tplu_pkg::bytes_t'(tplu_pkg::varint_len(ram_rdata - prev));
        prev <= ram_rdata;
      end
    end
    if (cmd.st_ld) begin
      res_status <= cmd.st_code;
    end
    if (cmd.val_ld) begin
      unique case (cmd.val_sel)
        tplu_pkg::VAL_ID:    res_value <= ram_rdata;
        tplu_pkg::VAL_BYTES: res_value <= 32'(bytes[islot]);
        tplu_pkg::VAL_TOTAL: res_value <= 32'(acc);
        default:             res_value <= types[tplu_pkg::slot_t'(pos)];
      endcase
    end
  end

  // Never more sections than slots, never open into a full table
  `TPLU_ASSERT_NOW(a_used_range, clk, rst, 1'b1, 32'(used) <= tplu_pkg::MAX_TYPES)
  `TPLU_ASSERT_NOW(a_open_room, clk, rst, cmd.open, 32'(used) < tplu_pkg::MAX_TYPES)

endmodule

`default_nettype wire

@@ tb/typed_posting_list_update_core_tb.sv @@
// Testbench for the typed posting line update core: directed table, fill tests, then random traffic.
// Depends on tplu_pkg for command and status codes; predicts results with its own model.
module typed_posting_list_update_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEC = 8;
  localparam int NIDS = 256;
  localparam int RAND_ITEMS = 600;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    tplu_pkg::cmd_t cmd;
    logic [31:0]    typ;
    logic [31:0]    doc;
    logic [7:0]     pos;
  } req_t;

  typedef struct {
    logic [2:0]  st;
    logic [31:0] val;
  } resp_t;

  typedef struct {
    req_t  rq;
    bit    fixed;
    resp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0] m_tuser;

  // Shadow of the posting line
  logic [31:0] sh_types [NSEC];
  int          sh_counts [NSEC];
  logic [31:0] sh_ids [NSEC][$];
  int          sh_used;

  resp_t pending_resp [$];
  int    n_bad = 0;
  int    n_resp = 0;
  int    n_sent = 0;
  longint cycles = 0;
  bit    sending_done = 0;
  row_t  dir_rows [$];

  typed_posting_list_update_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int vlen(logic [31:0] v);
    if (v < 32'h80) return 1;
    if (v < 32'h4000) return 2;
    if (v < 32'h20_0000) return 3;
    if (v < 32'h1000_0000) return 4;
    return 5;
  endfunction

  function automatic int sec_size(int s);
    int sum;
    logic [31:0] prev;
    sum = 0;
    prev = '0;
    for (int k = 0; k < sh_ids[s].size(); k++) begin
      sum += vlen(sh_ids[s][k] - prev);
      prev = sh_ids[s][k];
    end
    return sum;
  endfunction

  // Slot holding type t, or where it would be inserted
  function automatic int slot_of(logic [31:0] t, output bit hit);
    int i;
    i = 0;
    while (i < sh_used && sh_types[i] < t) i++;
    hit = (i < sh_used && sh_types[i] == t);
    return i;
  endfunction

  // Apply one request to the shadow and return the response it yields
  function automatic resp_t posting_apply(req_t r);
    resp_t o;
    bit hit;
    int s, k;
    o.st = tplu_pkg::STAT_OK;
    o.val = '0;
    case (r.cmd)
      tplu_pkg::CMD_ADD, tplu_pkg::CMD_DELETE: begin
        if (r.typ == 0 || r.doc == 0) begin
          o.st = tplu_pkg::STAT_ZERO;
          return o;
        end
        s = slot_of(r.typ, hit);
        if (r.cmd == tplu_pkg::CMD_DELETE) begin
          if (!hit) begin
            o.st = tplu_pkg::STAT_NOT_FOUND;
            return o;
          end
          k = 0;
          while (k < sh_counts[s] && sh_ids[s][k] < r.doc) k++;
          if (k >= sh_counts[s] || sh_ids[s][k] != r.doc) begin
            o.st = tplu_pkg::STAT_NOT_FOUND;
            return o;
          end
          sh_ids[s].delete(k);
          sh_counts[s]--;
          if (sh_counts[s] == 0) begin
            for (int j = s; j < sh_used - 1; j++) begin
              sh_types[j] = sh_types[j+1];
              sh_counts[j] = sh_counts[j+1];
              sh_ids[j] = sh_ids[j+1];
            end
            sh_used--;
            sh_ids[sh_used] = {};
            sh_counts[sh_used] = 0;
          end
          return o;
        end
        if (!hit) begin
          if (sh_used >= NSEC) begin
            o.st = tplu_pkg::STAT_FULL;
            return o;
          end
          for (int j = sh_used; j > s; j--) begin
            sh_types[j] = sh_types[j-1];
            sh_counts[j] = sh_counts[j-1];
            sh_ids[j] = sh_ids[j-1];
          end
          sh_types[s] = r.typ;
          sh_counts[s] = 0;
          sh_ids[s] = {};
          sh_used++;
        end
        k = 0;
        while (k < sh_counts[s] && sh_ids[s][k] < r.doc) k++;
        if (k < sh_counts[s] && sh_ids[s][k] == r.doc) return o;
        if (sh_counts[s] >= NIDS) begin
          o.st = tplu_pkg::STAT_FULL;
          return o;
        end
        sh_ids[s].insert(k, r.doc);
        sh_counts[s]++;
      end
      tplu_pkg::CMD_RD_ID: begin
        s = slot_of(r.typ, hit);
        if (!hit) o.st = tplu_pkg::STAT_NOT_FOUND;
        else if (r.pos >= sh_counts[s]) o.st = tplu_pkg::STAT_INDEX;
        else o.val = sh_ids[s][r.pos];
      end
      tplu_pkg::CMD_SEC_BY: begin
        s = slot_of(r.typ, hit);
        if (!hit) o.st = tplu_pkg::STAT_NOT_FOUND;
        else o.val = 32'(sec_size(s));
      end
      tplu_pkg::CMD_TOT_BY: begin
        o.val = 32'd1;
        for (int i = 0; i < sh_used; i++)
          o.val += 32'(vlen(sh_types[i]) + vlen(32'(sec_size(i))) + sec_size(i));
      end
      tplu_pkg::CMD_RD_TYP: begin
        if (r.pos >= sh_used) o.st = tplu_pkg::STAT_INDEX;
        else o.val = sh_types[r.pos];
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t mk(tplu_pkg::cmd_t c, logic [31:0] t, logic [31:0] d,
                              logic [7:0] p);
    req_t r;
    r.cmd = c;
    r.typ = t;
    r.doc = d;
    r.pos = p;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void put_row(req_t rq, bit fixed, resp_t want);
    row_t rw;
    rw.rq = rq;
    rw.fixed = fixed;
    rw.want = want;
    dir_rows.insert(dir_rows.size(), rw);
  endfunction

  // Hand one beat to the block; expectation is queued at acceptance
  task automatic send_beat(req_t r, bit fixed, resp_t want);
    resp_t got;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= r.cmd;
    s_tdata <= {8'h00, r.pos, r.doc, r.typ};
    do @(posedge clk); while (!s_tready);
    got = posting_apply(r);
    // Typed-in rows are checked against their own value, the rest against the predictor
    pending_resp.insert(pending_resp.size(), fixed ? want : got);
    n_sent++;
    // Keep valid high on back-to-back beats; drop only when a gap follows
    if ($urandom_range(0, 3) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(1, 127);
      2: return $urandom_range(128, 16383);
      3: return $urandom_range(1, 2000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_req(ref logic [31:0] tpool [$]);
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.typ = tpool[$urandom_range(0, tpool.size() - 1)];
    r.doc = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 300) : rand_word();
    r.pos = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    if (pick < 45) r.cmd = tplu_pkg::CMD_ADD;
    else if (pick < 65) r.cmd = tplu_pkg::CMD_DELETE;
    else if (pick < 77) r.cmd = tplu_pkg::CMD_RD_ID;
    else if (pick < 85) r.cmd = tplu_pkg::CMD_SEC_BY;
    else if (pick < 91) r.cmd = tplu_pkg::CMD_TOT_BY;
    else r.cmd = tplu_pkg::CMD_RD_TYP;
    // Delete mostly an id that is present, so sections drain and close
    if (r.cmd == tplu_pkg::CMD_DELETE && pick < 60) begin
      bit hit;
      int s;
      s = slot_of(r.typ, hit);
      if (hit) r.doc = sh_ids[s][$urandom_range(0, sh_counts[s] - 1)];
    end
    if ($urandom_range(0, 40) == 0) r.typ = '0;
    if ($urandom_range(0, 40) == 0) r.doc = '0;
    return r;
  endfunction

  // Receiver: stall pattern of its own, check each beat against the oldest expectation
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(0, 9) < 6) || (cycles % 2000 < 300);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      resp_t w;
      if (pending_resp.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected beat: status %0d value %h", m_tuser, m_tdata);
      end else begin
        w = pending_resp.pop_front();
        n_resp <= n_resp + 1;
        if (m_tuser !== w.st || m_tdata !== w.val) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch at result %0d: expected status %0d value %h, got %0d %h",
                     n_resp, w.st, w.val, m_tuser, m_tdata);
        end
      end
    end
  end

  initial begin
    logic [31:0] tpool [$];
    resp_t w;
    rst = 1'b1;
    for (int i = 0; i < NSEC; i++) begin
      sh_counts[i] = 0;
      sh_types[i] = '0;
      sh_ids[i] = {};
    end
    sh_used = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: fixed expectations on the obvious rows
    w.st = tplu_pkg::STAT_OK; w.val = 1;
    put_row(mk(tplu_pkg::CMD_TOT_BY, 0, 0, 0), 1, w);
    w.st = tplu_pkg::STAT_INDEX; w.val = 0;
    put_row(mk(tplu_pkg::CMD_RD_TYP, 0, 0, 0), 1, w);
    w.st = tplu_pkg::STAT_NOT_FOUND;
    put_row(mk(tplu_pkg::CMD_RD_ID, 0, 0, 0), 1, w);
    put_row(mk(tplu_pkg::CMD_SEC_BY, 5, 0, 0), 1, w);
    put_row(mk(tplu_pkg::CMD_DELETE, 5, 7, 0), 1, w);
    w.st = tplu_pkg::STAT_ZERO;
    put_row(mk(tplu_pkg::CMD_ADD, 0, 7, 0), 1, w);
    put_row(mk(tplu_pkg::CMD_ADD, 5, 0, 0), 1, w);
    put_row(mk(tplu_pkg::CMD_DELETE, 0, 0, 0), 1, w);
    w.st = tplu_pkg::STAT_OK;
    put_row(mk(tplu_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1, w);
    put_row(mk(tplu_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1, w);
    put_row(mk(tplu_pkg::CMD_ADD, 1, 1, 8'hFF), 1, w);
    put_row(mk(tplu_pkg::CMD_ADD, 1, 200, 0), 0, w);
    put_row(mk(tplu_pkg::CMD_ADD, 1, 20000, 0), 0, w);
    put_row(mk(tplu_pkg::CMD_ADD, 1, 32'h0AAA_AAAA, 0), 0, w);
    put_row(mk(tplu_pkg::CMD_SEC_BY, 1, 0, 0), 0, w);
    put_row(mk(tplu_pkg::CMD_TOT_BY, 0, 0, 0), 0, w);
    put_row(mk(tplu_pkg::CMD_RD_ID, 1, 0, 3), 0, w);
    put_row(mk(tplu_pkg::CMD_RD_TYP, 0, 0, 1), 0, w);
    w.st = tplu_pkg::STAT_INDEX; w.val = 0;
    put_row(mk(tplu_pkg::CMD_RD_ID, 1, 0, 8'hFF), 1, w);
    put_row(mk(tplu_pkg::CMD_RD_TYP, 0, 0, 8'hFF), 1, w);
    w.st = tplu_pkg::STAT_OK;
    // Delete the last id of a section, then one that empties its section
    put_row(mk(tplu_pkg::CMD_DELETE, 1, 32'h0AAA_AAAA, 0), 1, w);
    put_row(mk(tplu_pkg::CMD_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1, w);
    put_row(mk(tplu_pkg::CMD_SEC_BY, 1, 0, 0), 0, w);
    put_row(mk(tplu_pkg::cmd_t'(3'd6), 1, 1, 1), 1, w);
    put_row(mk(tplu_pkg::cmd_t'(3'd7), 32'h5555_5555, 32'hAAAA_AAAA, 8'h55), 1, w);
    foreach (dir_rows[i]) send_beat(dir_rows[i].rq, dir_rows[i].fixed, dir_rows[i].want);

    // Fill the table to force table-full, then fill one section to force section-full
    for (int i = 0; i < NSEC + 1; i++) begin
      w.st = (i < NSEC - 1) ? tplu_pkg::STAT_OK : tplu_pkg::STAT_FULL;
      send_beat(mk(tplu_pkg::CMD_ADD, 32'(100 + i * 1000), 3, 0), 0, w);
    end
    for (int i = 0; i < NIDS + 1; i++)
      send_beat(mk(tplu_pkg::CMD_ADD, 100, 32'hFFFF_FFFF - 32'(i * 977), 0), 0, w);
    for (int i = 0; i < 8; i++)
      send_beat(mk(tplu_pkg::CMD_DELETE, 32'(100 + i * 1000), 3, 0), 0, w);

    // Random traffic over a small pool of types so sections fill and drain
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 150 == 0) begin
        tpool = {};
        for (int j = 0; j < 10; j++) tpool.insert(tpool.size(), rand_word());
        tpool.insert(tpool.size(), 32'hFFFF_FFFF);
      end
      send_beat(rand_req(tpool), 0, w);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    sending_done = 1;
  end

  // End of run: drain, settle, report
  initial begin
    wait (sending_done);
    while (pending_resp.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d beats: adds, deletes, all queries, zero/full/not-found/index cases",
             n_sent);
    if (n_bad == 0 && pending_resp.size() == 0) $display("PASS typed_posting_list_update_core");
    else begin
      $display("%0d mismatches, %0d results outstanding", n_bad, pending_resp.size());
      $display("FAIL typed_posting_list_update_core");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("FAIL typed_posting_list_update_core");
    $finish;
  end
endmodule
